// ===== rtl/core/chm_pkg.sv =====
// Shared types, constants and hash functions of the coordinate-keyed hash map.
`default_nettype none

package chm_pkg;

    localparam int COORD_W = 32;
    localparam int MASK_W  = 12;
    localparam int CNT_W   = 13;
    localparam int KEY_W   = 24;
    localparam int VAL_W   = 8;
    localparam int ENTRY_W = 32;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [MASK_W-1:0] MASK_RESET = 12'hFFF;

    localparam logic [1:0] REG_OFFSET_X   = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y   = 2'd1;
    localparam logic [1:0] REG_OFFSET_Z   = 2'd2;
    localparam logic [1:0] REG_TABLE_MASK = 2'd3;

    localparam logic REQ_GET = 1'b0;
    localparam logic REQ_SET = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    localparam logic [31:0] HASH_MUL = 32'd2057;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX_B,
        ST_MIX_C,
        ST_LOOKUP,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Arithmetic (sign-filling) right shift of a 32-bit word.
    function automatic logic [31:0] sra32(input logic [31:0] v, input int n);
        logic [31:0] r;
        r = $signed(v) >>> n;
        return r;
    endfunction

    // First third of the integer mix.
    function automatic logic [31:0] mix_a(input logic [31:0] k);
        logic [31:0] t;
        t = ~k + (k << 15);
        return t ^ sra32(t, 12);
    endfunction

    // Second third of the integer mix.
    function automatic logic [31:0] mix_b(input logic [31:0] k);
        logic [31:0] t;
        t = k + (k << 2);
        return t ^ sra32(t, 4);
    endfunction

    // Last third of the integer mix.
    function automatic logic [31:0] mix_c(input logic [31:0] k);
        logic [31:0] t;
        t = k * HASH_MUL;
        return t ^ sra32(t, 16);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/chm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module chm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/coord_keyed_hash_map.sv =====
// Top level of the coordinate-keyed hash map: control, hashing, probing and register port.
`default_nettype none

// A hash table keyed by 3-D cell coordinates, held in one synchronous RAM of
// CAPACITY 32-bit slots (relative x, y, z and an 8-bit value; an all-zero slot
// is empty). After reset the block sweeps the whole RAM to zero, one slot per
// cycle, and takes no request until the sweep ends; register writes are taken
// during that time. Each request is handled on its own. The three absolute
// coordinates are hashed through a three-stage integer mix whose stages are
// each registered, and the home slot is formed from the last stage's result;
// the probe then reads one slot per cycle from the RAM's single read port
// until it finds the key, an empty slot, or has looked at every slot under
// the mask. An in-range request reads from one slot up to the effective mask
// plus one, and a request whose relative coordinates fall outside 0..255 is
// answered after the first mix stage, without a probe. A finished response waits
// in the output register, and the next request can be accepted while it does.
// A set that inserts is refused with the full status once the insert count
// would exceed half the mask; the count is never decremented.
module coord_keyed_hash_map
    import chm_pkg::*;
#(
    parameter int CAPACITY = 4096
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,

    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [ADDR_W-1:0]         paddr,
    input  wire logic [DATA_W-1:0]         pwdata,
    output logic      [DATA_W-1:0]         prdata,
    output logic                           pready,

    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic                      req_type,
    input  wire logic signed [COORD_W-1:0] coord_x,
    input  wire logic signed [COORD_W-1:0] coord_y,
    input  wire logic signed [COORD_W-1:0] coord_z,
    input  wire logic [VAL_W-1:0]          new_value,

    output logic                           rsp_valid,
    input  wire logic                      rsp_stall,
    output logic [VAL_W-1:0]               read_value,
    output logic                           changed,
    output logic [1:0]                     status
);

    localparam int IDX_W = $clog2(CAPACITY);
    // Common width for the load-limit comparison.
    localparam int LW    = (IDX_W > CNT_W + 1) ? IDX_W : CNT_W + 1;

    // Configuration registers.
    logic signed [COORD_W-1:0] offset_x_reg;
    logic signed [COORD_W-1:0] offset_y_reg;
    logic signed [COORD_W-1:0] offset_z_reg;
    logic [MASK_W-1:0]         table_mask_reg;

    // Control state.
    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              rsp_valid_reg, rsp_valid_next;

    // Request payload and working values.
    logic              is_set_reg, is_set_next;
    logic [VAL_W-1:0]  wval_reg, wval_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic              in_range_reg, in_range_next;
    logic [31:0]       hx_reg, hx_next;
    logic [31:0]       hy_reg, hy_next;
    logic [31:0]       hz_reg, hz_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [VAL_W-1:0]  res_value_reg, res_value_next;
    logic              res_changed_reg, res_changed_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [VAL_W-1:0]  read_value_reg, read_value_next;
    logic              changed_reg, changed_next;
    logic [1:0]        status_reg, status_next;

    // RAM port signals.
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;

    // Helper values.
    logic [31:0]        mask_wide;
    logic [IDX_W-1:0]   eff_mask;
    logic [IDX_W-1:0]   home;
    logic [IDX_W-1:0]   slot_inc;
    logic [COORD_W:0]   rel_x, rel_y, rel_z;
    logic               rel_ok;
    logic               accept;
    logic               cfg_write;
    logic               entry_empty;
    logic               entry_match;
    logic               probe_bound;
    logic               load_full;
    logic [CNT_W:0]     count_plus;

    chm_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Register port. Every address maps onto one of the four registers by
    // its word index; the port never waits.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_OFFSET_X:   prdata = offset_x_reg;
            REG_OFFSET_Y:   prdata = offset_y_reg;
            REG_OFFSET_Z:   prdata = offset_z_reg;
            REG_TABLE_MASK: prdata = DATA_W'(table_mask_reg);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_x_reg   <= '0;
            offset_y_reg   <= '0;
            offset_z_reg   <= '0;
            table_mask_reg <= MASK_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[3:2])
                REG_OFFSET_X:   offset_x_reg   <= pwdata;
                REG_OFFSET_Y:   offset_y_reg   <= pwdata;
                REG_OFFSET_Z:   offset_z_reg   <= pwdata;
                REG_TABLE_MASK: table_mask_reg <= pwdata[MASK_W-1:0];
                default:        offset_x_reg   <= offset_x_reg;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Derived values.
    // ------------------------------------------------------------------
    // The mask is cut down to the slots that physically exist.
    assign mask_wide = 32'(table_mask_reg);
    assign eff_mask  = mask_wide[IDX_W-1:0];

    assign home     = (hx_reg[IDX_W-1:0] ^ hy_reg[IDX_W-1:0] ^ hz_reg[IDX_W-1:0]) & eff_mask;
    assign slot_inc = (slot_reg + 1'b1) & eff_mask;

    // Relative coordinates are formed exactly in 33 bits; a coordinate is in
    // range when everything above its low byte is zero.
    assign rel_x  = {coord_x[COORD_W-1], coord_x} - {offset_x_reg[COORD_W-1], offset_x_reg};
    assign rel_y  = {coord_y[COORD_W-1], coord_y} - {offset_y_reg[COORD_W-1], offset_y_reg};
    assign rel_z  = {coord_z[COORD_W-1], coord_z} - {offset_z_reg[COORD_W-1], offset_z_reg};
    assign rel_ok = (rel_x[COORD_W:8] == '0) && (rel_y[COORD_W:8] == '0)
                 && (rel_z[COORD_W:8] == '0);

    assign entry_empty = (ram_rdata == '0);
    assign entry_match = (ram_rdata[KEY_W-1:0] == key_reg);
    assign probe_bound = (cnt_reg == eff_mask);

    // (count + 1) * 2 > mask is the same test as count + 1 > mask / 2.
    assign count_plus = {1'b0, count_reg} + 1'b1;
    assign load_full  = LW'(count_plus) > LW'(eff_mask >> 1);

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;

    // ------------------------------------------------------------------
    // Sequencer: next state, datapath updates and RAM control.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        clr_idx_next     = clr_idx_reg;
        cnt_next         = cnt_reg;
        count_next       = count_reg;
        rsp_valid_next   = rsp_valid_reg && rsp_stall;
        is_set_next      = is_set_reg;
        wval_next        = wval_reg;
        key_next         = key_reg;
        in_range_next    = in_range_reg;
        hx_next          = hx_reg;
        hy_next          = hy_reg;
        hz_next          = hz_reg;
        slot_next        = slot_reg;
        res_value_next   = res_value_reg;
        res_changed_next = res_changed_reg;
        res_status_next  = res_status_reg;
        read_value_next  = read_value_reg;
        changed_next     = changed_reg;
        status_next      = status_reg;
        ram_we           = 1'b0;
        ram_waddr        = slot_reg;
        ram_wdata        = {wval_reg, key_reg};
        ram_re           = 1'b0;
        ram_raddr        = slot_reg;

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_idx_reg;
                ram_wdata    = '0;
                clr_idx_next = clr_idx_reg + 1'b1;
                if (clr_idx_reg == '1)
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (accept)
                begin
                    is_set_next   = (req_type == REQ_SET);
                    wval_next     = new_value;
                    key_next      = {rel_z[7:0], rel_y[7:0], rel_x[7:0]};
                    in_range_next = rel_ok;
                    hx_next       = mix_a(coord_x);
                    hy_next       = mix_a(coord_y);
                    hz_next       = mix_a(coord_z);
                    state_next    = ST_MIX_B;
                end
            end

            ST_MIX_B:
            begin
                hx_next = mix_b(hx_reg);
                hy_next = mix_b(hy_reg);
                hz_next = mix_b(hz_reg);
                if (in_range_reg)
                begin
                    state_next = ST_MIX_C;
                end
                else
                begin
                    res_value_next   = '0;
                    res_changed_next = 1'b0;
                    res_status_next  = STAT_RANGE;
                    state_next       = ST_DONE;
                end
            end

            ST_MIX_C:
            begin
                hx_next    = mix_c(hx_reg);
                hy_next    = mix_c(hy_reg);
                hz_next    = mix_c(hz_reg);
                state_next = ST_LOOKUP;
            end

            ST_LOOKUP:
            begin
                ram_re     = 1'b1;
                ram_raddr  = home;
                slot_next  = home;
                cnt_next   = '0;
                state_next = ST_PROBE;
            end

            ST_PROBE:
            begin
                if (!entry_empty && !entry_match && !probe_bound)
                begin
                    // Occupied by another key: read the next slot at once.
                    ram_re    = 1'b1;
                    ram_raddr = slot_inc;
                    slot_next = slot_inc;
                    cnt_next  = cnt_reg + 1'b1;
                end
                else
                begin
                    res_value_next   = '0;
                    res_changed_next = 1'b0;
                    res_status_next  = STAT_OK;
                    state_next       = ST_DONE;
                    if (!is_set_reg)
                    begin
                        if (entry_match && !entry_empty)
                        begin
                            res_value_next = ram_rdata[ENTRY_W-1:KEY_W];
                        end
                    end
                    else if (entry_match && !entry_empty)
                    begin
                        if (ram_rdata[ENTRY_W-1:KEY_W] != wval_reg)
                        begin
                            ram_we           = 1'b1;
                            res_changed_next = 1'b1;
                        end
                    end
                    else if (wval_reg != '0)
                    begin
                        // Insert at the empty slot, unless the walk ran out
                        // of slots or the load limit is reached.
                        if (!entry_empty || load_full)
                        begin
                            res_status_next = STAT_FULL;
                        end
                        else
                        begin
                            ram_we           = 1'b1;
                            count_next       = count_plus[CNT_W-1:0];
                            res_changed_next = 1'b1;
                        end
                    end
                end
            end

            ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_valid_next  = 1'b1;
                    read_value_next = res_value_reg;
                    changed_next    = res_changed_reg;
                    status_next     = res_status_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_idx_reg   <= '0;
            cnt_reg       <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_idx_reg   <= clr_idx_next;
            cnt_reg       <= cnt_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_set_reg      <= is_set_next;
        wval_reg        <= wval_next;
        key_reg         <= key_next;
        in_range_reg    <= in_range_next;
        hx_reg          <= hx_next;
        hy_reg          <= hy_next;
        hz_reg          <= hz_next;
        slot_reg        <= slot_next;
        res_value_reg   <= res_value_next;
        res_changed_reg <= res_changed_next;
        res_status_reg  <= res_status_next;
        read_value_reg  <= read_value_next;
        changed_reg     <= changed_next;
        status_reg      <= status_next;
    end

    assign rsp_valid  = rsp_valid_reg;
    assign read_value = read_value_reg;
    assign changed    = changed_reg;
    assign status     = status_reg;

`ifndef SYNTHESIS
    // The probe never looks at more slots than the mask covers.
    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PROBE) |-> (cnt_reg <= eff_mask))
        else $error("probe walked past the mask");

    // The slot RAM is written only by the clearing sweep or at the end of a probe.
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_PROBE))
        else $error("slot RAM written outside the sweep or probe");

    // The insert count moves only when a probe finishes with an insert.
    a_count_move: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> ($past(state_reg) == ST_PROBE && $past(ram_we)))
        else $error("insert count changed outside a probe");

    // A request taken in idle always starts the hash pipeline.
    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_MIX_B))
        else $error("accepted request did not start hashing");

    // An out-of-range response never carries a value or a change.
    a_range_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status == STAT_RANGE) |-> (read_value == '0 && !changed))
        else $error("out-of-range response carries data");
`endif

endmodule

`default_nettype wire
